[rtl/kpc_pkg.sv]
// ---------------------------------------------------------------------------
// kpc_pkg: shared types and constants of the keyword prefix classifier
// Holds the keyword table, the field widths and the request and result
// structures passed between the classifier modules.
// ---------------------------------------------------------------------------
package kpc_pkg;

    // Field widths fixed by the interface.
    localparam int CHAR_W  = 8;
    localparam int CLASS_W = 6;
    localparam int SKIP_W  = 5;
    localparam int POS_W   = 5;

    // The position counter saturates at its top value.
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Size of the keyword table and the byte slots of each entry.
    localparam int KW_TABLE_SIZE = 36;
    localparam int KW_SLOTS      = 24;
    localparam int KW_BITS       = KW_SLOTS * CHAR_W;

    // Keyword text, right-aligned: the last character sits in the low byte.
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_TABLE_SIZE] = '{
        KW_BITS'("RigidBody"),
        KW_BITS'("/End"),
        KW_BITS'({"A_", "RigidBody"}),
        KW_BITS'("mesh"),
        KW_BITS'("mass"),
        KW_BITS'("moi"),
        KW_BITS'("colour"),
        KW_BITS'("root"),
        KW_BITS'("ArticulatedFigure"),
        KW_BITS'("child"),
        KW_BITS'("parent"),
        KW_BITS'("/ArticulatedFigure"),
        KW_BITS'("name"),
        KW_BITS'("Joint"),
        KW_BITS'("/Joint"),
        KW_BITS'("jointPPos"),
        KW_BITS'("jointCPos"),
        KW_BITS'({"CDP", "_Sphere"}),
        KW_BITS'({"CDP", "_Capsule"}),
        KW_BITS'({"CDP", "_Plane"}),
        KW_BITS'("static"),
        KW_BITS'("position"),
        KW_BITS'("orientation"),
        KW_BITS'("velocity"),
        KW_BITS'("angularVelocity"),
        KW_BITS'("frictionCoefficient"),
        KW_BITS'("restitutionCoefficient"),
        KW_BITS'("minBoundingSphere"),
        KW_BITS'("hingeJoint"),
        KW_BITS'("jointLimits"),
        KW_BITS'("universalJoint"),
        KW_BITS'("ballInSocketJoint"),
        KW_BITS'("CDP_Box"),
        KW_BITS'("planar"),
        KW_BITS'({"O", "DEGroundParameters"}),
        KW_BITS'("softBody")
    };

    // Character count of each keyword, in table order.
    localparam int KW_LEN [KW_TABLE_SIZE] = '{
        9, 4, 11, 4, 4, 3, 6, 4, 17, 5, 6, 18, 4, 5, 6, 9, 9, 10,
        11, 9, 6, 8, 11, 8, 15, 19, 22, 17, 10, 11, 14, 17, 7, 6, 19, 8
    };

    // One character of the line as it enters the matcher.
    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              line_end;
    } kpc_req_t;

    // Outcome of one character: whether a result is due, and its fields.
    typedef struct packed {
        logic               emit;
        logic [CLASS_W-1:0] line_class;
        logic [SKIP_W-1:0]  skip_length;
    } kpc_res_t;

    // Character of keyword k at position pos; zero past the keyword's end.
    function automatic logic [CHAR_W-1:0] kw_char(input int k, input logic [POS_W-1:0] pos);
        logic [KW_BITS-1:0] text;
        int                 len;
        int                 p;
        text = KW_TEXT[k];
        len  = KW_LEN[k];
        p    = int'(pos);
        if (p < len)
        begin
            kw_char = text[(len - 1 - p) * CHAR_W +: CHAR_W];
        end
        else
        begin
            kw_char = '0;
        end
    endfunction

endpackage

[rtl/kpc_match.sv]
// ---------------------------------------------------------------------------
// kpc_match: keyword match state and per-character decision
// Keeps the mask of surviving keywords, the position in the line and the
// decided flag, and compares one character against every keyword at once.
// ---------------------------------------------------------------------------
module kpc_match #(
    parameter int NUM_KEYWORDS    = 36,
    parameter int MAX_KEYWORD_LEN = 22
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  kpc_pkg::kpc_req_t req,
    output kpc_pkg::kpc_res_t res
);

    localparam int NUM_USED = (NUM_KEYWORDS > kpc_pkg::KW_TABLE_SIZE) ?
                              kpc_pkg::KW_TABLE_SIZE : NUM_KEYWORDS;
    localparam logic [NUM_KEYWORDS-1:0] FULL_MASK =
        {NUM_KEYWORDS{1'b1}} >> (NUM_KEYWORDS - NUM_USED);

    logic [NUM_KEYWORDS-1:0]      mask_reg;
    logic [NUM_KEYWORDS-1:0]      mask_next;
    logic [kpc_pkg::POS_W-1:0]    pos_reg;
    logic [kpc_pkg::POS_W-1:0]    pos_next;
    logic                         decided_reg;
    logic                         decided_next;

    logic [NUM_KEYWORDS-1:0]      alive_vec;
    logic [NUM_KEYWORDS-1:0]      done_vec;
    logic [kpc_pkg::SKIP_W-1:0]   len_vec [NUM_KEYWORDS];
    logic                         hit;
    logic [kpc_pkg::CLASS_W-1:0]  hit_class;
    logic [kpc_pkg::SKIP_W-1:0]   hit_len;

    // Compare the character with every keyword at the current position.
    for (genvar k = 0; k < NUM_KEYWORDS; k++)
    begin : g_kw
        if (k < NUM_USED)
        begin : g_used
            localparam int LEN_K = (kpc_pkg::KW_LEN[k] > MAX_KEYWORD_LEN) ?
                                   MAX_KEYWORD_LEN : kpc_pkg::KW_LEN[k];
            assign len_vec[k]   = kpc_pkg::SKIP_W'(LEN_K);
            assign alive_vec[k] = mask_reg[k] &&
                                  (int'(pos_reg) < LEN_K) &&
                                  (kpc_pkg::kw_char(k, pos_reg) == req.char_in);
            assign done_vec[k]  = alive_vec[k] && (int'(pos_reg) + 1 == LEN_K);
        end
        else
        begin : g_unused
            assign len_vec[k]   = '0;
            assign alive_vec[k] = 1'b0;
            assign done_vec[k]  = 1'b0;
        end
    end

    // The first keyword in table order that completes here wins.
    always_comb
    begin
        hit       = 1'b0;
        hit_class = '0;
        hit_len   = '0;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--)
        begin
            if (done_vec[k])
            begin
                hit       = 1'b1;
                hit_class = kpc_pkg::CLASS_W'(k + 1);
                hit_len   = len_vec[k];
            end
        end
    end

    // A result is due on a completed keyword, on no survivors, or at line end.
    always_comb
    begin
        res.emit        = !decided_reg && (hit || (alive_vec == '0) || req.line_end);
        res.line_class  = hit ? hit_class : '0;
        res.skip_length = hit ? hit_len : '0;
    end

    // Next state: line end returns everything to the start-of-line values.
    always_comb
    begin
        mask_next    = mask_reg;
        pos_next     = pos_reg;
        decided_next = decided_reg;
        if (req.line_end)
        begin
            mask_next    = FULL_MASK;
            pos_next     = '0;
            decided_next = 1'b0;
        end
        else if (!decided_reg)
        begin
            mask_next    = alive_vec & FULL_MASK;
            pos_next     = (pos_reg == kpc_pkg::POS_MAX) ? pos_reg :
                           pos_reg + kpc_pkg::POS_W'(1);
            decided_next = res.emit;
        end
    end

    // State registers, updated only when a character is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= FULL_MASK;
            pos_reg     <= '0;
            decided_reg <= 1'b0;
        end
        else if (fire)
        begin
            mask_reg    <= mask_next;
            pos_reg     <= pos_next;
            decided_reg <= decided_next;
        end
    end

`ifndef SYNTH
    // A matched keyword always reports a non-zero skip length.
    a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.emit && res.line_class != '0) |-> (res.skip_length != '0))
        else $error("kpc_match: keyword reported with zero length");

    // A line end leaves the matcher at the start of a fresh line.
    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req.line_end) |=> (pos_reg == '0 && !decided_reg && mask_reg == FULL_MASK))
        else $error("kpc_match: state not restored after line end");

    // Once decided, further characters of the line leave the state alone.
    a_decided_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && decided_reg && !req.line_end) |=> ($stable(mask_reg) && $stable(pos_reg)))
        else $error("kpc_match: state moved after decision");
`endif

endmodule

[rtl/keyword_prefix_classifier.sv]
// ---------------------------------------------------------------------------
// keyword_prefix_classifier: classify text lines by their leading keyword
// Top level with the input register, the matcher and the result register.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, char_in, line_end) carries one
// character of a line per request; line_end marks the final character.
// The output channel (out_valid, out_ready, line_class, skip_length) carries
// at most one request per line: the table index plus one of the keyword that
// begins the line, with its length, or class 0 and length 0 when none matches.
// A character is captured in the input register and compared against every
// keyword in the following cycle; a result it produces is written to the
// output register at the end of that cycle when the output register is
// free, and out_valid rises from that register.
// One character is accepted per cycle while any result it produces can enter
// the output register; the rate is set by the keyword mask and position update.
// After reset the block is at the start of a line with no pending requests.
// When the receiver stalls, a character that produces a result waits in the
// input register; characters that produce none still pass through.
// ---------------------------------------------------------------------------
module keyword_prefix_classifier #(
    parameter int NUM_KEYWORDS    = 36,
    parameter int MAX_KEYWORD_LEN = 22
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kpc_pkg::CHAR_W-1:0]    char_in,
    input  logic                          line_end,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [kpc_pkg::CLASS_W-1:0]   line_class,
    output logic [kpc_pkg::SKIP_W-1:0]    skip_length
);

    logic                          in_valid_reg;
    kpc_pkg::kpc_req_t             req_reg;
    logic                          out_valid_reg;
    logic [kpc_pkg::CLASS_W-1:0]   class_reg;
    logic [kpc_pkg::SKIP_W-1:0]    skip_reg;

    kpc_pkg::kpc_res_t             res;
    logic                          out_free;
    logic                          advance;

    // The held character moves on when its result, if any, has a place to go.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (out_free || !res.emit);
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg.char_in  <= char_in;
            req_reg.line_end <= line_end;
        end
    end

    // Keyword comparison and line state.
    kpc_match #(
        .NUM_KEYWORDS    (NUM_KEYWORDS),
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
    ) u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .req   (req_reg),
        .res   (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            class_reg <= res.line_class;
            skip_reg  <= res.skip_length;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_class  = class_reg;
    assign skip_length = skip_reg;

`ifndef SYNTH
    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res.emit) |-> out_free)
        else $error("keyword_prefix_classifier: result overwritten");

    // A held character that cannot advance is still held next cycle.
    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(req_reg)))
        else $error("keyword_prefix_classifier: held character lost");

    // A no-match result always carries a zero skip length.
    a_nomatch_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_class == '0) |-> (skip_length == '0))
        else $error("keyword_prefix_classifier: no-match result with length");
`endif

endmodule

[bench/kpc_bench_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kpc_bench_pkg: line classification scoreboard for the prefix classifier
// Tracks the keyword candidates of the current line as characters are
// accepted, queues the class each line should receive and checks the
// results that the classifier returns against that queue.
// ---------------------------------------------------------------------------
package kpc_bench_pkg;

    localparam int NUM_KW     = kpc_pkg::KW_TABLE_SIZE;
    localparam int MAX_KW_LEN = 22;

    // Class and skip length that one line should receive.
    typedef struct packed {
        logic [kpc_pkg::CLASS_W-1:0] line_class;
        logic [kpc_pkg::SKIP_W-1:0]  skip_length;
    } line_verdict_t;

    // Byte p of keyword k, counted from its first character.
    function automatic logic [kpc_pkg::CHAR_W-1:0] keyword_byte(input int k, input int p);
        logic [kpc_pkg::KW_BITS-1:0] text;
        text = kpc_pkg::KW_TEXT[k] >> ((kpc_pkg::KW_LEN[k] - 1 - p) * kpc_pkg::CHAR_W);
        return text[kpc_pkg::CHAR_W-1:0];
    endfunction

    // Number of characters that must match for keyword k to complete.
    function automatic int keyword_length(input int k);
        return (kpc_pkg::KW_LEN[k] > MAX_KW_LEN) ? MAX_KW_LEN : kpc_pkg::KW_LEN[k];
    endfunction

    class keyword_class_scoreboard;

        logic [NUM_KW-1:0]          live_keywords;
        logic [kpc_pkg::POS_W-1:0]  line_pos;
        bit                         settled;
        line_verdict_t              expected_verdicts[$];
        bit [NUM_KW:0]              classes_seen;
        int                         classified_chars;
        int                         lines_seen;
        int                         verdicts_checked;
        int                         mismatches;

        function new();
            restart_line();
            classes_seen     = '0;
            classified_chars = 0;
            lines_seen       = 0;
            verdicts_checked = 0;
            mismatches       = 0;
        endfunction

        // A new line starts with every keyword still a candidate.
        function void restart_line();
            live_keywords = '1;
            line_pos      = '0;
            settled       = 1'b0;
        endfunction

        // Advance the candidate set by one accepted character and queue the
        // verdict for the line once it is decided.
        function void note_char(input logic [kpc_pkg::CHAR_W-1:0] c, input logic is_end);
            logic [NUM_KW-1:0] survivors;
            int                hit;
            int                hit_len;
            int                len;
            line_verdict_t     verdict;
            if (!settled)
            begin
                survivors = '0;
                hit       = 0;
                hit_len   = 0;
                classified_chars++;
                for (int k = 0; k < NUM_KW; k++)
                begin
                    len = keyword_length(k);
                    if (live_keywords[k] && int'(line_pos) < len &&
                        keyword_byte(k, int'(line_pos)) == c)
                    begin
                        survivors[k] = 1'b1;
                        if (len == int'(line_pos) + 1 && hit == 0)
                        begin
                            hit     = k + 1;
                            hit_len = len;
                        end
                    end
                end
                live_keywords = survivors;
                if (line_pos != kpc_pkg::POS_MAX)
                begin
                    line_pos++;
                end
                // A completed keyword wins; otherwise a dead set or the end
                // of the line gives the no-match class.
                if (hit != 0 || survivors == '0 || is_end)
                begin
                    verdict.line_class  = kpc_pkg::CLASS_W'(hit);
                    verdict.skip_length = kpc_pkg::SKIP_W'(hit_len);
                    expected_verdicts.push_back(verdict);
                    classes_seen[hit] = 1'b1;
                    settled = 1'b1;
                end
            end
            if (is_end)
            begin
                lines_seen++;
                restart_line();
            end
        endfunction

        // Compare one returned result with the oldest queued verdict.
        function void check_result(input logic [kpc_pkg::CLASS_W-1:0] got_class,
                                   input logic [kpc_pkg::SKIP_W-1:0]  got_skip);
            line_verdict_t want;
            if (expected_verdicts.size() == 0)
            begin
                flag($sformatf("Unexpected result: class %0d skip %0d",
                               got_class, got_skip));
            end
            else
            begin
                want = expected_verdicts.pop_front();
                verdicts_checked++;
                if (got_class !== want.line_class || got_skip !== want.skip_length)
                begin
                    flag($sformatf("Result %0d: class %0d skip %0d, expected class %0d skip %0d",
                                   verdicts_checked, got_class, got_skip,
                                   want.line_class, want.skip_length));
                end
            end
        endfunction

        // Only the first few mismatches are shown; the rest are counted.
        function void flag(input string what);
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%s", what);
            end
        endfunction

        function int pending();
            return expected_verdicts.size();
        endfunction

    endclass

endpackage

[bench/tb_keyword_prefix_classifier.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_keyword_prefix_classifier: self-checking bench for the prefix classifier
// Feeds directed lines covering early line ends, zero and all-ones bytes,
// dead candidate sets and characters after the decision, then random lines
// built mostly from whole, cut, altered or case-flipped keywords with some
// noise. Sender bursts and receiver stall patterns vary throughout; every
// result is checked against a scoreboard that tracks the candidate set.
// ---------------------------------------------------------------------------
module tb_keyword_prefix_classifier;

    typedef logic [kpc_pkg::CHAR_W-1:0] char_q_t[$];

    typedef enum int {
        LINE_KEYWORD,
        LINE_TRUNCATED,
        LINE_MUTATED,
        LINE_CASE_FLIP,
        LINE_NOISE
    } line_kind_t;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    localparam int RANDOM_CHARS = 450;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        in_valid    = 1'b0;
    logic                        in_ready;
    logic [kpc_pkg::CHAR_W-1:0]  char_in     = '0;
    logic                        line_end    = 1'b0;
    logic                        out_valid;
    logic                        out_ready   = 1'b0;
    logic [kpc_pkg::CLASS_W-1:0] line_class;
    logic [kpc_pkg::SKIP_W-1:0]  skip_length;

    kpc_bench_pkg::keyword_class_scoreboard class_board = new();

    int       burst_left     = 0;
    int       sent_chars     = 0;
    rx_mode_t rx_mode        = RX_ALWAYS;
    int       rx_mode_left   = 0;
    logic [3:0] stall_phase  = '0;

    keyword_prefix_classifier u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .line_end    (line_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .line_class  (line_class),
        .skip_length (skip_length)
    );

    always #10 clk = ~clk;

    // Receiver readiness: switches between randomly chosen patterns.
    always @(posedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 80);
        end
        else
        begin
            rx_mode_left--;
        end
        stall_phase <= stall_phase + 1'b1;
        case (rx_mode)
            RX_ALWAYS:   out_ready <= 1'b1;
            RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
            default:     out_ready <= stall_phase[1];
        endcase
    end

    // Accepted requests feed the scoreboard; returned results are checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                class_board.note_char(char_in, line_end);
            end
            if (out_valid && out_ready)
            begin
                class_board.check_result(line_class, skip_length);
            end
        end
    end

    // Offer one character and hold it until the classifier takes it.
    task automatic send_char(input logic [kpc_pkg::CHAR_W-1:0] c, input logic is_end);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        sent_chars++;
        char_in  <= c;
        line_end <= is_end;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_line(input char_q_t line);
        for (int i = 0; i < line.size(); i++)
        begin
            send_char(line[i], i == line.size() - 1);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Stop sending until every queued verdict has been returned.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (class_board.pending() != 0) @(posedge clk);
    endtask

    // Build one random line, mostly around a real keyword.
    task automatic send_random_line();
        char_q_t    line;
        line_kind_t kind;
        int         pick;
        int         k;
        int         len;
        int         spot;
        int         cut;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            kind = LINE_KEYWORD;
        else if (pick < 70)
            kind = LINE_TRUNCATED;
        else if (pick < 80)
            kind = LINE_MUTATED;
        else if (pick < 88)
            kind = LINE_CASE_FLIP;
        else
            kind = LINE_NOISE;
        k    = $urandom_range(0, kpc_bench_pkg::NUM_KW - 1);
        len  = kpc_bench_pkg::keyword_length(k);
        line = {};
        if (kind == LINE_NOISE)
        begin
            // Raw bytes, with the zero and all-ones values given extra weight.
            repeat ($urandom_range(1, 5))
            begin
                pick = $urandom_range(0, 5);
                line.push_back(pick == 0 ? 8'h00 :
                               pick == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
            end
        end
        else if (kind == LINE_TRUNCATED)
        begin
            cut = $urandom_range(1, len - 1);
            for (int p = 0; p < cut; p++)
            begin
                line.push_back(kpc_bench_pkg::keyword_byte(k, p));
            end
        end
        else
        begin
            for (int p = 0; p < len; p++)
            begin
                line.push_back(kpc_bench_pkg::keyword_byte(k, p));
            end
            spot = $urandom_range(0, len - 1);
            if (kind == LINE_MUTATED)
            begin
                line[spot] = line[spot] ^ 8'($urandom_range(1, 255));
            end
            else if (kind == LINE_CASE_FLIP)
            begin
                line[spot] = line[spot] ^ 8'h20;
            end
            // A short tail after the keyword is ignored by the classifier.
            repeat ($urandom_range(0, 2))
            begin
                line.push_back(8'($urandom_range(0, 255)));
            end
        end
        send_line(line);
    endtask

    // Main sequence: reset, directed lines, random lines, drain and verdict.
    initial
    begin
        bit drained_mid;
        drained_mid = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Keyword completing on the final character of the line.
        send_text("moi");
        // Keyword followed by characters that must be ignored.
        send_text("/End!?");
        // Line ending before the keyword completes.
        send_text("ma");
        // A zero byte kills every candidate at once.
        send_char(8'h00, 1'b0);
        send_char("m", 1'b1);
        // Single all-ones byte as a whole line.
        send_char(8'hFF, 1'b1);
        // Candidates die part way through; the rest of the line is ignored.
        send_text("Jxz");
        // Matching is case-sensitive on the last character.
        send_text("mesH");
        wait_drained();

        while (sent_chars < RANDOM_CHARS)
        begin
            send_random_line();
            if (!drained_mid && sent_chars >= RANDOM_CHARS / 2)
            begin
                wait_drained();
                drained_mid = 1'b1;
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Run covered %0d lines and %0d classified characters; %0d results checked.",
                 class_board.lines_seen, class_board.classified_chars,
                 class_board.verdicts_checked);
        $display("Distinct keywords reported: %0d of %0d; no-match class seen: %0d.",
                 $countones(class_board.classes_seen[kpc_bench_pkg::NUM_KW:1]),
                 kpc_bench_pkg::NUM_KW, class_board.classes_seen[0]);
        if (class_board.mismatches == 0 && class_board.pending() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("Mismatches: %0d, results never returned: %0d",
                     class_board.mismatches, class_board.pending());
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", class_board.pending());
        $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/kpc_pkg.sv
rtl/kpc_match.sv
rtl/keyword_prefix_classifier.sv
bench/kpc_bench_pkg.sv
bench/tb_keyword_prefix_classifier.sv
